// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define MFQC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle
`define MFQC_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// ----- rtl/mfqc_pkg.sv -----
// Package with shared constants and types of the mesh face quality checker
`timescale 1ns / 1ps

package mfqc_pkg;

   localparam int COORD_W     = 32;
   localparam int LEN_W       = 31;
   localparam int CELL_W      = 20;
   localparam int PATCH_W     = 16;
   localparam int INDEX_W     = 20;
   localparam int TOL_W       = 32;
   localparam int COS_W       = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int FRAC_BITS   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MID_TOL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_TOL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_THR  = 2'd2;

   localparam logic [TOL_W-1:0] MID_TOL_RESET  = 32'd6554;
   localparam logic [TOL_W-1:0] PROJ_TOL_RESET = 32'd6554;
   localparam logic [COS_W-1:0] COS_THR_RESET  = 17'd22415;

   // wide multiplier: A in 4 limbs, B in 3 limbs of 32 bits
   localparam int LIMB_W      = 32;
   localparam int MUL_A_LIMBS = 4;
   localparam int MUL_B_LIMBS = 3;
   localparam int MUL_A_W     = LIMB_W * MUL_A_LIMBS;
   localparam int MUL_B_W     = LIMB_W * MUL_B_LIMBS;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int MUL_ROW_W   = MUL_A_W + LIMB_W;

   // squared one in the fixed-point scale
   localparam int ONE_SQ_SHIFT = 2 * FRAC_BITS;

   // squared-form widths
   localparam int D2_W  = 69;
   localparam int N2_W  = 65;
   localparam int C2_W  = 67;
   localparam int DOT_W = 66;

   typedef struct packed {
      logic                internal;
      logic [CELL_W-1:0]   owner;
      logic [PATCH_W-1:0]  patch;
      logic [INDEX_W-1:0]  index;
      logic [D2_W-1:0]     d2;
      logic [N2_W-1:0]     n2;
      logic                czero;
      logic                nzero;
   } track_type;

   typedef struct packed {
      logic [MUL_P_W-1:0] mid_rhs;
      logic [MUL_P_W-1:0] dot2;
      logic [MUL_P_W-1:0] cr2;
   } wide_type;

endpackage

// ----- rtl/mfqc_mul.sv -----
// Three-stage wide unsigned multiplier built from 32x32 partial products
`timescale 1ns / 1ps

module mfqc_mul import mfqc_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [MUL_P_W-1:0] p
);

   logic [2*LIMB_W-1:0]  pp_ff  [MUL_B_LIMBS][MUL_A_LIMBS];
   logic [2*LIMB_W-1:0]  pp_in  [MUL_B_LIMBS][MUL_A_LIMBS];
   logic [MUL_ROW_W-1:0] row_ff [MUL_B_LIMBS];
   logic [MUL_ROW_W-1:0] row_in [MUL_B_LIMBS];
   logic [MUL_P_W-1:0]   sum_ff;
   logic [MUL_P_W-1:0]   sum_in;

   always_comb begin
      for (int j = 0; j < MUL_B_LIMBS; j++) begin
         for (int i = 0; i < MUL_A_LIMBS; i++) begin
            pp_in[j][i] = (2*LIMB_W)'(a[LIMB_W*i +: LIMB_W]) *
                          (2*LIMB_W)'(b[LIMB_W*j +: LIMB_W]);
         end
      end
   end

   // sum each row of partial products
   always_comb begin
      for (int j = 0; j < MUL_B_LIMBS; j++) begin
         row_in[j] = '0;
         for (int i = 0; i < MUL_A_LIMBS; i++) begin
            row_in[j] = row_in[j] + (MUL_ROW_W'(pp_ff[j][i]) << (LIMB_W * i));
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < MUL_B_LIMBS; j++) begin
         sum_in = sum_in + (MUL_P_W'(row_ff[j]) << (LIMB_W * j));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff  <= pp_in;
         row_ff <= row_in;
         sum_ff <= sum_in;
      end
   end

   assign p = sum_ff;

endmodule

// ----- rtl/mesh_face_quality_checker.sv -----
// Top level of the mesh face quality checker: ten-stage face pipeline
`timescale 1ns / 1ps
//
//  channel | direction | handshake                      | payload
//  req     | in        | req_valid / req_stall          | one face per transaction
//  rsp     | out       | rsp_valid / rsp_stall          | index, copies, three warnings
//  csr     | in        | csr_write_enable               | csr_index, csr_write_data
//
//  One face enters per cycle unless the pipeline is stalled; each result leaves from the result register.
//  Most of the pipeline depth comes from the two chained three-stage wide multipliers.
//  Reset clears the valid bits and the face counter and loads the three configuration registers with their defaults.
//  A held result stalls the whole pipeline; req_stall rises in that cycle.
//  The face counter wraps at 2^20.

module mesh_face_quality_checker import mfqc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // face input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_is_internal,
   input  logic [CELL_W-1:0]     req_owner_cell,
   input  logic [PATCH_W-1:0]    req_patch_number,
   input  logic signed [COORD_W-1:0] req_owner_x,
   input  logic signed [COORD_W-1:0] req_owner_y,
   input  logic signed [COORD_W-1:0] req_neighbour_x,
   input  logic signed [COORD_W-1:0] req_neighbour_y,
   input  logic signed [COORD_W-1:0] req_face_x,
   input  logic signed [COORD_W-1:0] req_face_y,
   input  logic signed [COORD_W-1:0] req_normal_x_in,
   input  logic signed [COORD_W-1:0] req_normal_y_in,
   input  logic [LEN_W-1:0]      req_face_length,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [INDEX_W-1:0]    rsp_face_index,
   output logic [CELL_W-1:0]     rsp_owner_out,
   output logic [PATCH_W-1:0]    rsp_patch_out,
   output logic                  rsp_midpoint_warning,
   output logic                  rsp_orthogonality_warning,
   output logic                  rsp_projection_warning,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

`include "assert_macros.svh"

   localparam int STAGES = 10;
   localparam int TRACK  = 7;   // track stages 3..9
   localparam int WDLY   = 3;   // wide results delayed from stage 6 to 9

   // ---------------- configuration and control ----------------
   logic [TOL_W-1:0]   mid_tol_ff;
   logic [TOL_W-1:0]   proj_tol_ff;
   logic [COS_W-1:0]   cos_thr_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [STAGES-1:0]  vld_ff;
   logic               en;
   logic               accept;

   // advance everything unless the result register is held
   assign en        = !(vld_ff[STAGES-1] && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_tol_ff  <= MID_TOL_RESET;
         proj_tol_ff <= PROJ_TOL_RESET;
         cos_thr_ff  <= COS_THR_RESET;
         idx_ff      <= '0;
         vld_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_MID_TOL:  mid_tol_ff  <= csr_write_data;
               CSR_PROJ_TOL: proj_tol_ff <= csr_write_data;
               CSR_COS_THR:  cos_thr_ff  <= csr_write_data[COS_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (en) begin
            vld_ff <= {vld_ff[STAGES-2:0], req_valid};
         end
      end
   end

   // ---------------- stage 1: differences ----------------
   logic                     s1_int_ff;
   logic [CELL_W-1:0]        s1_owner_ff;
   logic [PATCH_W-1:0]       s1_patch_ff;
   logic [INDEX_W-1:0]       s1_idx_ff;
   logic signed [34:0]       s1_dmx_ff, s1_dmy_ff;   // 2f - o - n
   logic signed [32:0]       s1_cx_ff, s1_cy_ff;     // n - o
   logic signed [32:0]       s1_ex_ff, s1_ey_ff;     // f - o
   logic signed [COORD_W-1:0] s1_nx_ff, s1_ny_ff;
   logic [LEN_W-1:0]         s1_len_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_int_ff   <= req_is_internal;
         s1_owner_ff <= req_owner_cell;
         s1_patch_ff <= req_patch_number;
         s1_idx_ff   <= idx_ff;
         s1_dmx_ff   <= (35'(req_face_x) <<< 1) - 35'(req_owner_x) - 35'(req_neighbour_x);
         s1_dmy_ff   <= (35'(req_face_y) <<< 1) - 35'(req_owner_y) - 35'(req_neighbour_y);
         s1_cx_ff    <= 33'(req_neighbour_x) - 33'(req_owner_x);
         s1_cy_ff    <= 33'(req_neighbour_y) - 33'(req_owner_y);
         s1_ex_ff    <= 33'(req_face_x) - 33'(req_owner_x);
         s1_ey_ff    <= 33'(req_face_y) - 33'(req_owner_y);
         s1_nx_ff    <= req_normal_x_in;
         s1_ny_ff    <= req_normal_y_in;
         s1_len_ff   <= req_face_length;
      end
   end

   // ---------------- stage 2: narrow products ----------------
   logic [33:0] mag_dmx, mag_dmy;
   logic [32:0] mag_cx, mag_cy;
   logic [31:0] mag_nx, mag_ny;
   logic signed [64:0] w_cx, w_cy, w_ex, w_ey, w_nx, w_ny;

   assign mag_dmx = s1_dmx_ff[34] ? 34'(-s1_dmx_ff) : 34'(s1_dmx_ff);
   assign mag_dmy = s1_dmy_ff[34] ? 34'(-s1_dmy_ff) : 34'(s1_dmy_ff);
   assign mag_cx  = s1_cx_ff[32] ? 33'(-s1_cx_ff) : 33'(s1_cx_ff);
   assign mag_cy  = s1_cy_ff[32] ? 33'(-s1_cy_ff) : 33'(s1_cy_ff);
   assign mag_nx  = s1_nx_ff[31] ? 32'(-s1_nx_ff) : 32'(s1_nx_ff);
   assign mag_ny  = s1_ny_ff[31] ? 32'(-s1_ny_ff) : 32'(s1_ny_ff);
   assign w_cx    = 65'(s1_cx_ff);
   assign w_cy    = 65'(s1_cy_ff);
   assign w_ex    = 65'(s1_ex_ff);
   assign w_ey    = 65'(s1_ey_ff);
   assign w_nx    = 65'(s1_nx_ff);
   assign w_ny    = 65'(s1_ny_ff);

   logic               s2_int_ff;
   logic [CELL_W-1:0]  s2_owner_ff;
   logic [PATCH_W-1:0] s2_patch_ff;
   logic [INDEX_W-1:0] s2_idx_ff;
   logic [67:0]        s2_sq_dmx_ff, s2_sq_dmy_ff;
   logic [65:0]        s2_sq_cx_ff, s2_sq_cy_ff;
   logic [63:0]        s2_sq_nx_ff, s2_sq_ny_ff;
   logic signed [64:0] s2_cnx_ff, s2_cny_ff, s2_eny_ff, s2_enx_ff;
   logic [61:0]        s2_sq_len_ff;
   logic [63:0]        s2_t2_ff, s2_pt2_ff;
   logic [33:0]        s2_thr2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_int_ff    <= s1_int_ff;
         s2_owner_ff  <= s1_owner_ff;
         s2_patch_ff  <= s1_patch_ff;
         s2_idx_ff    <= s1_idx_ff;
         s2_sq_dmx_ff <= 68'(mag_dmx) * 68'(mag_dmx);
         s2_sq_dmy_ff <= 68'(mag_dmy) * 68'(mag_dmy);
         s2_sq_cx_ff  <= 66'(mag_cx) * 66'(mag_cx);
         s2_sq_cy_ff  <= 66'(mag_cy) * 66'(mag_cy);
         s2_sq_nx_ff  <= 64'(mag_nx) * 64'(mag_nx);
         s2_sq_ny_ff  <= 64'(mag_ny) * 64'(mag_ny);
         s2_cnx_ff    <= w_cx * w_nx;
         s2_cny_ff    <= w_cy * w_ny;
         s2_eny_ff    <= w_ex * w_ny;
         s2_enx_ff    <= w_ey * w_nx;
         s2_sq_len_ff <= 62'(s1_len_ff) * 62'(s1_len_ff);
         s2_t2_ff     <= 64'(mid_tol_ff) * 64'(mid_tol_ff);
         s2_pt2_ff    <= 64'(proj_tol_ff) * 64'(proj_tol_ff);
         s2_thr2_ff   <= 34'(cos_thr_ff) * 34'(cos_thr_ff);
      end
   end

   // ---------------- stage 3: squared norms, dot and cross ----------------
   localparam logic [C2_W-1:0] ONE_SQ_C = C2_W'(1) << ONE_SQ_SHIFT;
   localparam logic [61:0]     ONE_SQ_L = 62'(1) << ONE_SQ_SHIFT;

   logic [C2_W-1:0]    c2;
   logic [N2_W-1:0]    n2;
   logic signed [DOT_W-1:0] dot_s, cr_s;

   assign c2    = C2_W'(s2_sq_cx_ff) + C2_W'(s2_sq_cy_ff);
   assign n2    = N2_W'(s2_sq_nx_ff) + N2_W'(s2_sq_ny_ff);
   assign dot_s = DOT_W'(s2_cnx_ff) + DOT_W'(s2_cny_ff);
   assign cr_s  = DOT_W'(s2_eny_ff) - DOT_W'(s2_enx_ff);

   track_type          tr_ff [TRACK];
   logic [C2_W-1:0]    s3_mc_ff, s3_c2_ff;
   logic [61:0]        s3_ml_ff;
   logic [DOT_W-1:0]   s3_dot_ff, s3_cr_ff;
   logic [63:0]        s3_t2_ff, s3_pt2_ff;
   logic [33:0]        s3_thr2_ff;
   track_type          tr_in;

   always_comb begin
      tr_in.internal = s2_int_ff;
      tr_in.owner    = s2_owner_ff;
      tr_in.patch    = s2_patch_ff;
      tr_in.index    = s2_idx_ff;
      tr_in.d2       = D2_W'(s2_sq_dmx_ff) + D2_W'(s2_sq_dmy_ff);
      tr_in.n2       = n2;
      tr_in.czero    = (c2 == '0);
      tr_in.nzero    = (n2 == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tr_ff[0]   <= tr_in;
         for (int k = 1; k < TRACK; k++) begin
            tr_ff[k] <= tr_ff[k-1];
         end
         s3_c2_ff   <= c2;
         s3_mc_ff   <= (c2 > ONE_SQ_C) ? c2 : ONE_SQ_C;
         s3_ml_ff   <= (s2_sq_len_ff > ONE_SQ_L) ? s2_sq_len_ff : ONE_SQ_L;
         s3_dot_ff  <= dot_s[DOT_W-1] ? DOT_W'(-dot_s) : DOT_W'(dot_s);
         s3_cr_ff   <= cr_s[DOT_W-1] ? DOT_W'(-cr_s) : DOT_W'(cr_s);
         s3_t2_ff   <= s2_t2_ff;
         s3_pt2_ff  <= s2_pt2_ff;
         s3_thr2_ff <= s2_thr2_ff;
      end
   end

   // ---------------- stages 4-6: first wide products ----------------
   logic [MUL_P_W-1:0] p_mid, p_dot2, p_pc, p_pq, p_cr2;

   mfqc_mul u_mul_mid (
      .clock (clock), .en (en),
      .a (MUL_A_W'(s3_mc_ff)), .b (MUL_B_W'(s3_t2_ff)), .p (p_mid)
   );
   mfqc_mul u_mul_dot (
      .clock (clock), .en (en),
      .a (MUL_A_W'(s3_dot_ff)), .b (MUL_B_W'(s3_dot_ff)), .p (p_dot2)
   );
   mfqc_mul u_mul_cos (
      .clock (clock), .en (en),
      .a (MUL_A_W'(s3_c2_ff)), .b (MUL_B_W'(s3_thr2_ff)), .p (p_pc)
   );
   mfqc_mul u_mul_len (
      .clock (clock), .en (en),
      .a (MUL_A_W'(s3_ml_ff)), .b (MUL_B_W'(s3_pt2_ff)), .p (p_pq)
   );
   mfqc_mul u_mul_cross (
      .clock (clock), .en (en),
      .a (MUL_A_W'(s3_cr_ff)), .b (MUL_B_W'(s3_cr_ff)), .p (p_cr2)
   );

   // ---------------- stages 7-9: products with |normal|^2 ----------------
   logic [MUL_P_W-1:0] p_orth_rhs, p_proj_rhs;

   mfqc_mul u_mul_orth (
      .clock (clock), .en (en),
      .a (p_pc[MUL_A_W-1:0]), .b (MUL_B_W'(tr_ff[3].n2)), .p (p_orth_rhs)
   );
   mfqc_mul u_mul_proj (
      .clock (clock), .en (en),
      .a (p_pq[MUL_A_W-1:0]), .b (MUL_B_W'(tr_ff[3].n2)), .p (p_proj_rhs)
   );

   // hold the first-round results alongside
   wide_type wd_ff [WDLY];
   wide_type wd_in;

   always_comb begin
      wd_in.mid_rhs = p_mid;
      wd_in.dot2    = p_dot2;
      wd_in.cr2     = p_cr2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wd_ff[0] <= wd_in;
         for (int k = 1; k < WDLY; k++) begin
            wd_ff[k] <= wd_ff[k-1];
         end
      end
   end

   // ---------------- stage 10: compares and result register ----------------
   track_type          tr9;
   wide_type           wd9;
   logic [MUL_P_W-1:0] mid_lhs, mid_rhs, orth_lhs, proj_lhs;
   logic               mid_w, orth_w, proj_w;

   assign tr9      = tr_ff[TRACK-1];
   assign wd9      = wd_ff[WDLY-1];
   assign mid_lhs  = MUL_P_W'(tr9.d2) << ONE_SQ_SHIFT;
   assign mid_rhs  = wd9.mid_rhs << 2;
   assign orth_lhs = wd9.dot2 << ONE_SQ_SHIFT;
   assign proj_lhs = wd9.cr2 << ONE_SQ_SHIFT;

   always_comb begin
      mid_w  = tr9.internal && (mid_lhs > mid_rhs);
      orth_w = 1'b0;
      if (tr9.internal) begin
         // a zero-length vector counts as cosine zero
         orth_w = (tr9.czero || tr9.nzero) ? (cos_thr_ff != '0) : (orth_lhs < p_orth_rhs);
      end
      proj_w = !tr9.internal && !tr9.nzero && (proj_lhs > p_proj_rhs);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_face_index            <= tr9.index;
         rsp_owner_out             <= tr9.owner;
         rsp_patch_out             <= tr9.patch;
         rsp_midpoint_warning      <= mid_w;
         rsp_orthogonality_warning <= orth_w;
         rsp_projection_warning    <= proj_w;
      end
   end

   assign rsp_valid = vld_ff[STAGES-1];

   // ---------------- checks ----------------
   `MFQC_ASSERT_NEXT(a_count_step, accept, idx_ff == INDEX_W'($past(idx_ff) + 1'b1), "face counter did not advance by one")
   `MFQC_ASSERT_NEXT(a_boundary_flags, en && vld_ff[STAGES-2] && !tr9.internal, !rsp_midpoint_warning && !rsp_orthogonality_warning, "internal-face warning on boundary face")
   `MFQC_ASSERT(a_stall_cause, !req_stall || (rsp_valid && rsp_stall), "input stalled without a held result")

endmodule
